[rtl/core/rhzb_pkg.sv]
// Shared types and constants for the RMSSD zone binning unit.
package rhzb_pkg;

    localparam int ZONES      = 6;
    localparam int ZONE_W     = 3;
    localparam int LIMITS     = 5;
    localparam int ROOT_STEPS = 11;
    localparam int DIV_STEPS  = 32;
    localparam logic [10:0] MEAN_MAX = 11'd2047;
    localparam logic [ZONE_W-1:0] ZONE_NONE = 3'd6;

    localparam logic [2:0] REG_ZONE_LIMIT_1 = 3'd0;
    localparam logic [2:0] REG_ZONE_LIMIT_2 = 3'd1;
    localparam logic [2:0] REG_ZONE_LIMIT_3 = 3'd2;
    localparam logic [2:0] REG_ZONE_LIMIT_4 = 3'd3;
    localparam logic [2:0] REG_ZONE_LIMIT_5 = 3'd4;

    typedef struct packed {
        logic              win;
        logic [31:0]       dss;
        logic [7:0]        bpm;
        logic [ZONE_W-1:0] qzone;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQRT,
        B_BIN,
        B_MDIV,
        B_STATS,
        B_OUT
    } back_state_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[rtl/core/rhzb_front.sv]
// Front end: arming, window fill and squared-difference accumulation.
module rhzb_front #(
    parameter int WINDOW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [10:0]   rr_ms,
    input  logic [7:0]    bpm,
    input  logic          has_stamp,
    input  logic [2:0]    query_zone,
    input  logic          q_full,
    output logic          in_ready,
    output logic          push,
    output rhzb_pkg::job_t job
);
    import rhzb_pkg::*;

    localparam int FW = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam logic [FW-1:0] FILL_LAST = FW'(WINDOW - 1);

    logic          armed_reg, armed_next;
    logic [10:0]   prev_reg, prev_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [31:0]   dss_reg, dss_next;
    logic [10:0]   diff;
    logic [21:0]   sq;
    logic [31:0]   dss_sum;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        diff    = (rr_ms >= prev_reg) ? (rr_ms - prev_reg) : (prev_reg - rr_ms);
        sq      = diff * diff;
        dss_sum = dss_reg + ((fill_reg != '0) ? {10'd0, sq} : 32'd0);

        armed_next = armed_reg;
        prev_next  = prev_reg;
        fill_next  = fill_reg;
        dss_next   = dss_reg;
        job.win    = 1'b0;
        job.dss    = dss_sum;
        job.bpm    = bpm;
        job.qzone  = query_zone;
        if (has_stamp)
        begin
            if (!armed_reg)
            begin
                armed_next = 1'b1;
            end
            else
            begin
                prev_next = rr_ms;
                if (fill_reg == FILL_LAST)
                begin
                    job.win   = 1'b1;
                    fill_next = '0;
                    dss_next  = 32'd0;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    dss_next  = dss_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            prev_reg  <= '0;
            fill_reg  <= '0;
            dss_reg   <= '0;
        end
        else if (push)
        begin
            armed_reg <= armed_next;
            prev_reg  <= prev_next;
            fill_reg  <= fill_next;
            dss_reg   <= dss_next;
        end
    end

endmodule

[rtl/core/rhzb_fifo.sv]
// Two-entry job queue between front and back.
module rhzb_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rhzb_pkg::job_t wdata,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output rhzb_pkg::job_t rdata
);
    import rhzb_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/core/rhzb_div.sv]
// Restoring 32-bit divider, one quotient bit per cycle.
module rhzb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import rhzb_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [32:0] rem_sh;
    logic [32:0] trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_sh = {rem_reg[31:0], quo_reg[31]};
        trial  = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/rhzb_back.sv]
// Back end: window RMSSD, zone binning, zone statistics and result register.
module rhzb_back #(
    parameter int WINDOW = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  rhzb_pkg::job_t         q_data,
    output logic                   pop,
    input  logic [4:0][7:0]        limits,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [143:0]           out_data,
    output rhzb_pkg::back_state_t  state
);
    import rhzb_pkg::*;

    localparam logic [31:0] WM1 = 32'(WINDOW - 1);

    back_state_t state_reg, state_next;
    job_t        job_reg;

    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q;

    logic [10:0] root_reg, sbit_reg;
    logic [3:0]  scnt_reg;
    logic [10:0] root_try;
    logic [21:0] try_sq;
    logic [31:0] try_prod;

    logic [10:0]       rmssd_reg;
    logic              done_reg, err_reg;
    logic [ZONE_W-1:0] zidx_reg, last_reg, idx_reg;
    logic [31:0]       sum_reg  [ZONES];
    logic [31:0]       cnt_reg  [ZONES];
    logic [10:0]       mean_reg [ZONES];
    logic [31:0]       maxc_reg, tot_reg, qc_reg;
    logic [10:0]       maxm_reg, qm_reg;
    logic              ovalid_reg;
    logic [143:0]      odata_reg;

    logic [ZONE_W-1:0] zone;
    logic [10:0]       rm;
    logic [31:0]       sum_new, cnt_new;
    logic [10:0]       mean_q;

    function automatic logic [ZONE_W-1:0] find_zone(input logic [7:0] b,
                                                     input logic [4:0][7:0] lim);
        logic [ZONE_W-1:0] z;
        logic              lo, hi;
        z = ZONE_NONE;
        for (int k = ZONES - 1; k >= 0; k--)
        begin
            lo = (k == 0) ? 1'b1 : (b >= lim[(k == 0) ? 0 : k - 1]);
            hi = (k == ZONES - 1) ? 1'b1 : (b < lim[(k == ZONES - 1) ? 0 : k]);
            if (lo && hi)
            begin
                z = ZONE_W'(k);
            end
        end
        return z;
    endfunction

    rhzb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign state     = state_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // root search: largest r with r*r*(WINDOW-1) <= sum, which equals
    // floor(sqrt(floor(sum / (WINDOW-1)))); r never exceeds 2047
    always_comb
    begin
        zone     = find_zone(job_reg.bpm, limits);
        rm       = root_reg;
        sum_new  = sat_add32(sum_reg[zone], {21'd0, rm});
        cnt_new  = sat_add32(cnt_reg[zone], 32'd1);
        mean_q   = (div_q > 32'd2047) ? MEAN_MAX : div_q[10:0];
        root_try = root_reg | sbit_reg;
        try_sq   = root_try * root_try;
        try_prod = {10'd0, try_sq} * WM1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (q_valid) state_next = q_data.win ? B_SQRT : B_STATS;
            B_SQRT:  if (scnt_reg == 4'(ROOT_STEPS - 1)) state_next = B_BIN;
            B_BIN:   state_next = (zone != ZONE_NONE) ? B_MDIV : B_STATS;
            B_MDIV:  if (div_done) state_next = B_STATS;
            B_STATS: if (idx_reg == ZONE_W'(ZONES - 1)) state_next = B_OUT;
            B_OUT:   if (!ovalid_reg) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_a     = sum_new;
        div_b     = cnt_new;
        case (state_reg)
            B_IDLE:
            begin
                pop = q_valid;
            end
            B_BIN:
            begin
                div_start = (zone != ZONE_NONE);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= q_data;
                idx_reg  <= '0;
                maxc_reg <= '0;
                maxm_reg <= '0;
                tot_reg  <= '0;
                qc_reg   <= '0;
                qm_reg   <= '0;
                root_reg <= '0;
                sbit_reg <= 11'h400;
                scnt_reg <= '0;
            end
            B_SQRT:
            begin
                if (try_prod <= job_reg.dss)
                begin
                    root_reg <= root_try;
                end
                sbit_reg <= sbit_reg >> 1;
                scnt_reg <= scnt_reg + 1'b1;
            end
            B_STATS:
            begin
                if (cnt_reg[idx_reg] > maxc_reg) maxc_reg <= cnt_reg[idx_reg];
                if (mean_reg[idx_reg] > maxm_reg) maxm_reg <= mean_reg[idx_reg];
                tot_reg <= sat_add32(tot_reg, cnt_reg[idx_reg]);
                if (idx_reg == job_reg.qzone)
                begin
                    qc_reg <= cnt_reg[idx_reg];
                    qm_reg <= mean_reg[idx_reg];
                end
                idx_reg <= idx_reg + 1'b1;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (state_reg == B_OUT && !ovalid_reg)
        begin
            odata_reg <= {7'd0, last_reg, tot_reg, maxm_reg, maxc_reg, qm_reg, qc_reg,
                          err_reg, zidx_reg, rmssd_reg, done_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
            last_reg   <= '0;
            done_reg   <= 1'b0;
            err_reg    <= 1'b0;
            zidx_reg   <= '0;
            rmssd_reg  <= '0;
            for (int i = 0; i < ZONES; i++)
            begin
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                mean_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        done_reg  <= 1'b0;
                        err_reg   <= 1'b0;
                        zidx_reg  <= '0;
                        rmssd_reg <= '0;
                    end
                end
                B_BIN:
                begin
                    rmssd_reg <= rm;
                    if (zone != ZONE_NONE)
                    begin
                        sum_reg[zone] <= sum_new;
                        cnt_reg[zone] <= cnt_new;
                        last_reg      <= zone;
                        zidx_reg      <= zone;
                        done_reg      <= 1'b1;
                    end
                    else
                    begin
                        err_reg <= 1'b1;
                    end
                end
                B_MDIV:
                begin
                    if (div_done)
                    begin
                        mean_reg[zidx_reg] <= mean_q;
                    end
                end
                B_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    last_reg <= last_reg;
                end
            endcase
        end
    end

endmodule

[rtl/core/rmssd_hrv_zone_binning_unit.sv]
// Top level of the RMSSD zone binning unit: register port, front, queue, back.
//
//  channel   dir  handshake            content
//  s_*       in   s_tvalid/s_tready    one RR sample per beat
//  m_*       out  m_tvalid/m_tready    one result per beat
//  APB       in   psel/penable/pready  zone limit registers at 0x00..0x10
//
// A beat without a completed window holds the back for pop, zone sweep and
// result load. A completing beat holds it for pop, root search against
// WINDOW-1, bin, zone mean divide when the bpm falls in a zone, sweep, load.
// The front takes a beat whenever the two-entry queue has room; the result
// register holds while m_tready is low and the back stalls behind it.
// Reset clears all zone statistics at once; no clearing pass.
module rmssd_hrv_zone_binning_unit #(
    parameter int WINDOW = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // rr_ms[10:0], bpm[18:11], query_zone[21:19], zero pad
    input  logic         s_tuser,   // has_stamp
    output logic         m_tvalid,
    input  logic         m_tready,
    // window_done, rmssd, zone_index, zone_error, query_count, query_mean,
    // max_count, max_mean, total_count, current_zone, zero pad
    output logic [143:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rhzb_pkg::*;

    logic [4:0][7:0] lim_reg;
    logic [2:0]      reg_idx;
    logic            q_full, q_valid, push, pop;
    job_t            f_job, q_job;
    back_state_t     bstate;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        case (reg_idx)
            REG_ZONE_LIMIT_1: prdata = {24'd0, lim_reg[0]};
            REG_ZONE_LIMIT_2: prdata = {24'd0, lim_reg[1]};
            REG_ZONE_LIMIT_3: prdata = {24'd0, lim_reg[2]};
            REG_ZONE_LIMIT_4: prdata = {24'd0, lim_reg[3]};
            REG_ZONE_LIMIT_5: prdata = {24'd0, lim_reg[4]};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg[0] <= 8'd70;
            lim_reg[1] <= 8'd108;
            lim_reg[2] <= 8'd143;
            lim_reg[3] <= 8'd161;
            lim_reg[4] <= 8'd178;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                REG_ZONE_LIMIT_1: lim_reg[0] <= pwdata[7:0];
                REG_ZONE_LIMIT_2: lim_reg[1] <= pwdata[7:0];
                REG_ZONE_LIMIT_3: lim_reg[2] <= pwdata[7:0];
                REG_ZONE_LIMIT_4: lim_reg[3] <= pwdata[7:0];
                REG_ZONE_LIMIT_5: lim_reg[4] <= pwdata[7:0];
                default:          lim_reg    <= lim_reg;
            endcase
        end
    end

    rhzb_front #(.WINDOW(WINDOW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .rr_ms      (s_tdata[10:0]),
        .bpm        (s_tdata[18:11]),
        .has_stamp  (s_tuser),
        .query_zone (s_tdata[21:19]),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .job        (f_job)
    );

    rhzb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_job),
        .pop   (pop),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_job)
    );

    rhzb_back #(.WINDOW(WINDOW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_job),
        .pop       (pop),
        .limits    (lim_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .state     (bstate)
    );

    a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[15]))
        else $error("result flags both window done and zone error");

    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:12] <= 3'd5 && m_tdata[136:134] <= 3'd5))
        else $error("zone field out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (bstate == B_IDLE && q_valid))
        else $error("queue popped outside idle");

    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (bstate == B_SQRT) |=> !$rose(m_tvalid))
        else $error("result raised while root in progress");

endmodule
